// File: design/tmt_pkg.sv
// ============================================================================
// tmt_pkg: shared types and constants for the text mode terminal
// Screen geometry, operation and command codes, item structs, address math.
// ============================================================================
package tmt_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROW_SUM_W = ROW_W + 1;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ADDR_W    = $clog2(CELLS);

    // Port field widths
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;

    // Character and attribute constants
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_COLOUR = 8'h0F;

    // Operation codes on the input channel
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_BKSP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Classified command codes
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_PUT       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEWLINE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BKSP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_NONE = 3'd5;

    // Command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_colour;
        logic       scrolled;
    } out_item_t;

    typedef struct packed {
        logic [CMD_W-1:0] kind;
        logic [7:0]       ch;
        logic [ROW_W-1:0] rd_row;
        logic [COL_W-1:0] rd_col;
    } cmd_t;

    // Store address of a logical (row, col); base is the store row holding
    // logical row 0 (scrolling rotates it).
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] base,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [ROW_SUM_W-1:0] sum;
        logic [ADDR_W-1:0]    row_start;
        sum = {1'b0, base} + {1'b0, row};
        if (sum >= ROW_SUM_W'(ROWS)) begin
            sum = sum - ROW_SUM_W'(ROWS);
        end
        row_start = ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS);
        return row_start + ADDR_W'(col);
    endfunction

endpackage

// File: design/tmt_front.sv
// ============================================================================
// tmt_front: input stage
// Accepts items, decodes them into commands and hands them to the queue.
// ============================================================================
module tmt_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tmt_pkg::in_item_t s_item,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output tmt_pkg::cmd_t    cmd
);

    logic          cmd_valid_reg;
    logic          cmd_valid_next;
    tmt_pkg::cmd_t cmd_reg;
    tmt_pkg::cmd_t cmd_next;
    logic          accept;

    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next        = cmd_reg;
        cmd_valid_next  = cmd_valid_reg;
        if (cmd_valid_reg && cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
        if (accept) begin
            cmd_valid_next = 1'b1;
            cmd_next.ch     = s_item.char_code;
            cmd_next.rd_row = tmt_pkg::ROW_W'(s_item.read_row);
            cmd_next.rd_col = tmt_pkg::COL_W'(s_item.read_col);
            unique case (s_item.op)
                tmt_pkg::OP_PUT: begin
                    cmd_next.kind = (s_item.char_code == tmt_pkg::NEWLINE_CODE) ?
                                    tmt_pkg::CMD_NEWLINE : tmt_pkg::CMD_PUT;
                end
                tmt_pkg::OP_BKSP: begin
                    cmd_next.kind = tmt_pkg::CMD_BKSP;
                end
                tmt_pkg::OP_CLEAR: begin
                    cmd_next.kind = tmt_pkg::CMD_CLEAR;
                end
                default: begin
                    // off-screen reads return zeros and touch nothing
                    if ((int'(s_item.read_row) < tmt_pkg::ROWS) &&
                        (int'(s_item.read_col) < tmt_pkg::COLUMNS)) begin
                        cmd_next.kind = tmt_pkg::CMD_READ;
                    end else begin
                        cmd_next.kind = tmt_pkg::CMD_READ_NONE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

// File: design/tmt_cmd_fifo.sv
// ============================================================================
// tmt_cmd_fifo: command queue
// Short queue between the decode stage and the execution engine.
// ============================================================================
module tmt_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  tmt_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop,
    output tmt_pkg::cmd_t pop_data
);

    tmt_pkg::cmd_t                     slot_reg [tmt_pkg::FIFO_DEPTH];
    logic [tmt_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [tmt_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [tmt_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg != tmt_pkg::FIFO_CNT_W'(tmt_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/tmt_back.sv
// ============================================================================
// tmt_back: execution engine
// Owns the screen store, cursor and scroll base; runs commands and sweeps.
// ============================================================================
module tmt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         text_colour,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  tmt_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output tmt_pkg::out_item_t m_item
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    localparam int ADDR_W = tmt_pkg::ADDR_W;
    localparam int ROW_W  = tmt_pkg::ROW_W;
    localparam int COL_W  = tmt_pkg::COL_W;

    logic [15:0]       mem [tmt_pkg::CELLS];
    logic [15:0]       rdata_reg;

    logic [1:0]        state_reg,       state_next;
    logic [ROW_W-1:0]  row_reg,         row_next;
    logic [COL_W-1:0]  col_reg,         col_next;
    logic [ROW_W-1:0]  base_reg,        base_next;
    logic [ADDR_W-1:0] sweep_addr_reg,  sweep_addr_next;
    logic [ADDR_W-1:0] sweep_end_reg,   sweep_end_next;
    logic [7:0]        sweep_colour_reg, sweep_colour_next;
    logic              m_valid_reg,     m_valid_next;
    tmt_pkg::out_item_t m_item_reg,     m_item_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign mem_raddr = tmt_pkg::cell_addr(base_reg, cmd.rd_row, cmd.rd_col);

    always_comb begin
        logic             emit;
        logic             scr;
        logic [ADDR_W-1:0] top_addr;

        state_next        = state_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        base_next         = base_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_end_next    = sweep_end_reg;
        sweep_colour_next = sweep_colour_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_item_next       = m_item_reg;
        cmd_pop           = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = sweep_addr_reg;
        mem_wdata         = {sweep_colour_reg, tmt_pkg::SPACE_CODE};
        emit              = 1'b0;
        scr               = 1'b0;
        top_addr          = tmt_pkg::cell_addr(base_reg, '0, '0);

        unique case (state_reg)
            ST_SWEEP: begin
                mem_we = 1'b1;
                if (sweep_addr_reg == sweep_end_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_item_next.cursor_row  = tmt_pkg::OUT_ROW_W'(row_reg);
                m_item_next.cursor_col  = tmt_pkg::OUT_COL_W'(col_reg);
                m_item_next.cell_char   = rdata_reg[7:0];
                m_item_next.cell_colour = rdata_reg[15:8];
                m_item_next.scrolled    = 1'b0;
                state_next = ST_IDLE;
            end
            default: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind) inside
                        tmt_pkg::CMD_PUT, tmt_pkg::CMD_NEWLINE: begin
                            emit = 1'b1;
                            if (cmd.kind == tmt_pkg::CMD_PUT) begin
                                mem_we    = 1'b1;
                                mem_waddr = tmt_pkg::cell_addr(base_reg, row_reg, col_reg);
                                mem_wdata = {text_colour, cmd.ch};
                            end
                            if ((cmd.kind == tmt_pkg::CMD_NEWLINE) ||
                                (col_reg == COL_W'(tmt_pkg::COLUMNS - 1))) begin
                                col_next = '0;
                                if (row_reg == ROW_W'(tmt_pkg::ROWS - 1)) begin
                                    // scroll: old top row becomes the new bottom
                                    scr = 1'b1;
                                    base_next = (base_reg == ROW_W'(tmt_pkg::ROWS - 1)) ?
                                                '0 : base_reg + 1'b1;
                                    sweep_addr_next   = top_addr;
                                    sweep_end_next    = top_addr +
                                                        ADDR_W'(tmt_pkg::COLUMNS - 1);
                                    sweep_colour_next = text_colour;
                                    state_next        = ST_SWEEP;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                end
                            end else begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        tmt_pkg::CMD_BKSP: begin
                            emit = 1'b1;
                            if (col_reg != '0) begin
                                col_next = col_reg - 1'b1;
                            end else if (row_reg != '0) begin
                                row_next = row_reg - 1'b1;
                                col_next = COL_W'(tmt_pkg::COLUMNS - 1);
                            end
                            mem_we    = 1'b1;
                            mem_waddr = tmt_pkg::cell_addr(base_reg, row_next, col_next);
                            mem_wdata = {text_colour, tmt_pkg::SPACE_CODE};
                        end
                        tmt_pkg::CMD_CLEAR: begin
                            emit              = 1'b1;
                            row_next          = '0;
                            col_next          = '0;
                            base_next         = '0;
                            sweep_addr_next   = '0;
                            sweep_end_next    = ADDR_W'(tmt_pkg::CELLS - 1);
                            sweep_colour_next = text_colour;
                            state_next        = ST_SWEEP;
                        end
                        tmt_pkg::CMD_READ: begin
                            // store read issued now, data lands in rdata_reg
                            state_next = ST_READ;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                    if (emit) begin
                        m_valid_next = 1'b1;
                        m_item_next.cursor_row  = tmt_pkg::OUT_ROW_W'(row_next);
                        m_item_next.cursor_col  = tmt_pkg::OUT_COL_W'(col_next);
                        m_item_next.cell_char   = '0;
                        m_item_next.cell_colour = '0;
                        m_item_next.scrolled    = scr;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // power-up clearing pass over the whole store
            state_reg        <= ST_SWEEP;
            row_reg          <= '0;
            col_reg          <= '0;
            base_reg         <= '0;
            sweep_addr_reg   <= '0;
            sweep_end_reg    <= ADDR_W'(tmt_pkg::CELLS - 1);
            sweep_colour_reg <= tmt_pkg::RESET_COLOUR;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            base_reg         <= base_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_end_reg    <= sweep_end_next;
            sweep_colour_reg <= sweep_colour_next;
            m_valid_reg      <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

// File: design/text_mode_terminal.sv
// ============================================================================
// text_mode_terminal: 80x25 character-cell text terminal
// Screen store, cursor, scrolling, backspace, clear and cell read-back.
// ============================================================================
// Usage:
//   One item per operation on s_valid/s_ready/s_item: put character
//   (newline moves to the start of the next row), backspace, clear, read
//   cell. Each item gives one result item on m_valid/m_ready/m_item: the
//   cursor after the operation, the read cell (reads only), a scroll flag.
//   cfg_wr_en/cfg_wr_data set text_colour for every written or blanked
//   cell; write it only while no item is in flight.
// Pipeline and throughput:
//   Decode register, 2-entry command queue, then the engine (one write and
//   one registered read of the screen store per cycle). With m_ready high
//   the rate is one item per cycle, an on-screen read also passing through
//   the ST_READ state. A scroll adds a row sweep (the row base rotates,
//   cells stay put) and a clear a sweep of the whole store before the next
//   command.
// Reset (aresetn, synchronous, active low):
//   Cursor homes, text_colour returns to 0x0F and a clearing pass blanks
//   the store; three items are buffered meanwhile, then s_ready drops.
//   Stalls: a result waits in the output register while m_ready is low;
//   items queue until full, then s_ready goes low.
//
module text_mode_terminal (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tmt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tmt_pkg::out_item_t m_item,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data
);

    // text colour register
    logic [7:0]    text_colour_reg;

    // decode stage -> queue
    logic          dec_valid;
    logic          dec_ready;
    tmt_pkg::cmd_t dec_cmd;

    // queue -> engine
    logic          q_valid;
    logic          q_pop;
    tmt_pkg::cmd_t q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_colour_reg <= tmt_pkg::RESET_COLOUR;
        end else if (cfg_wr_en) begin
            text_colour_reg <= cfg_wr_data;
        end
    end

    // front: accept and classify
    tmt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (dec_valid),
        .cmd_ready (dec_ready),
        .cmd       (dec_cmd)
    );

    // decouples the front from sweeps and output stalls
    tmt_cmd_fifo u_cmd_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (dec_valid),
        .push_ready (dec_ready),
        .push_data  (dec_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_cmd)
    );

    // back: screen store, cursor and result register
    tmt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .text_colour (text_colour_reg),
        .cmd_valid   (q_valid),
        .cmd_pop     (q_pop),
        .cmd         (q_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

// File: design/tmt_checker.sv
// ============================================================================
// tmt_checker: port-level checks for the text mode terminal
// Result handshake, reset behavior and cursor bounds.
// ============================================================================
module tmt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tmt_pkg::out_item_t m_item
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // cursor always on screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_item.cursor_row) < tmt_pkg::ROWS) &&
                    (int'(m_item.cursor_col) < tmt_pkg::COLUMNS))
        else $error("cursor off screen");

    // a scroll leaves the cursor at the start of the bottom row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.scrolled |->
            (int'(m_item.cursor_row) == tmt_pkg::ROWS - 1) && (m_item.cursor_col == '0))
        else $error("scroll with cursor not at bottom row start");

endmodule

bind text_mode_terminal tmt_checker u_tmt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
